// ----- design/rsqa_pkg.sv -----
// Shared constants and helper functions for the reciprocal square root pipeline.
package rsqa_pkg;

  localparam logic [31:0] RSQRT_MAGIC = 32'h5f3759df;
  localparam logic [31:0] F_HALF      = 32'h3f000000;
  localparam logic [31:0] F_ONE_HALF  = 32'h3fc00000;
  localparam logic [31:0] F_QNAN      = 32'hffc00000;
  localparam logic [31:0] F_QUIET_BIT = 32'h00400000;
  localparam int          RDLY        = 9;

  // leading zero count over a 48-bit product
  function automatic logic [5:0] clz48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // leading zero count over a 27-bit significand with guard bits
  function automatic logic [4:0] clz27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

endpackage

// ----- design/rsqa_fmul.sv -----
// Three-stage single-precision multiplier with round-to-nearest-even.
module rsqa_fmul import rsqa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_v,
  output logic [31:0] p
);

  // stage 1: unpack, specials, significand product
  logic        v1_r, s1_r, sp1_r;
  logic [31:0] spv1_r;
  logic [47:0] prod1_r;
  logic signed [9:0] e1_r;

  logic [7:0]  ea, eb, eae, ebe;
  logic        az, bz, ai, bi, an, bn, sgn;
  logic        sp_nxt;
  logic [31:0] spv_nxt;

  always_comb begin
    ea  = a[30:23];
    eb  = b[30:23];
    eae = (ea == 8'd0) ? 8'd1 : ea;
    ebe = (eb == 8'd0) ? 8'd1 : eb;
    az  = (ea == 8'd0) && (a[22:0] == 23'd0);
    bz  = (eb == 8'd0) && (b[22:0] == 23'd0);
    ai  = (ea == 8'hff) && (a[22:0] == 23'd0);
    bi  = (eb == 8'hff) && (b[22:0] == 23'd0);
    an  = (ea == 8'hff) && (a[22:0] != 23'd0);
    bn  = (eb == 8'hff) && (b[22:0] != 23'd0);
    sgn = a[31] ^ b[31];
    sp_nxt  = 1'b1;
    spv_nxt = {sgn, 31'd0};
    if (an)                             spv_nxt = a | F_QUIET_BIT;
    else if (bn)                        spv_nxt = b | F_QUIET_BIT;
    else if ((ai && bz) || (bi && az))  spv_nxt = F_QNAN;
    else if (ai || bi)                  spv_nxt = {sgn, 8'hff, 23'd0};
    else if (az || bz)                  spv_nxt = {sgn, 31'd0};
    else                                sp_nxt  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= sgn;
      sp1_r   <= sp_nxt;
      spv1_r  <= spv_nxt;
      prod1_r <= {ea != 8'd0, a[22:0]} * {eb != 8'd0, b[22:0]};
      e1_r    <= $signed({2'b00, eae}) + $signed({2'b00, ebe}) - 10'sd127;
    end
  end

  // stage 2: normalize, or align into the subnormal range
  logic        v2_r, s2_r, sp2_r, st2_r, ovf2_r;
  logic [31:0] spv2_r;
  logic [47:0] m2_r;
  logic [7:0]  ef2_r;

  logic [5:0]  lz;
  logic signed [10:0] ex;
  logic [47:0] m_nxt;
  logic [6:0]  ramt;
  logic [95:0] wide;
  logic        st_nxt;
  logic [7:0]  ef_nxt;
  logic        ovf_nxt;

  always_comb begin
    lz      = clz48(prod1_r);
    ex      = 11'(e1_r) + 11'sd1 - $signed({5'd0, lz});
    ramt    = 7'(-e1_r);
    wide    = {prod1_r, 48'd0} >> ramt;
    st_nxt  = 1'b0;
    ovf_nxt = 1'b0;
    ef_nxt  = 8'd0;
    if (ex >= 11'sd1) begin
      m_nxt   = prod1_r << lz;
      ovf_nxt = ex >= 11'sd255;
      ef_nxt  = ex[7:0];
    end else if (e1_r >= 10'sd0) begin
      m_nxt = prod1_r << e1_r[5:0];
    end else begin
      m_nxt  = wide[95:48];
      st_nxt = |wide[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r   <= s1_r;
      sp2_r  <= sp1_r;
      spv2_r <= spv1_r;
      m2_r   <= m_nxt;
      st2_r  <= st_nxt;
      ef2_r  <= ef_nxt;
      ovf2_r <= ovf_nxt;
    end
  end

  // stage 3: round and pack; a carry out of the fraction bumps the exponent
  logic        v3_r;
  logic [31:0] p3_r;
  logic        inc;
  logic [30:0] mag;
  logic [31:0] p_nxt;

  always_comb begin
    inc = m2_r[23] & ((|m2_r[22:0]) | st2_r | m2_r[24]);
    mag = {ef2_r, m2_r[46:24]} + {30'd0, inc};
    if (sp2_r)       p_nxt = spv2_r;
    else if (ovf2_r) p_nxt = {s2_r, 8'hff, 23'd0};
    else             p_nxt = {s2_r, mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r <= p_nxt;
    end
  end

  assign out_v = v3_r;
  assign p     = p3_r;

endmodule

// ----- design/rsqa_fsub.sv -----
// Three-stage single-precision subtractor (a - b) with round-to-nearest-even.
module rsqa_fsub import rsqa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_v,
  output logic [31:0] d
);

  // stage 1: specials, order by magnitude, align the smaller operand
  logic        v1_r, sub1_r, s1_r, z1_r, sp1_r;
  logic [31:0] spv1_r;
  logic [26:0] big1_r, sml1_r;
  logic [7:0]  e1_r;

  logic        sbn, an, bn, ai, bi, swp, sl, sp_nxt;
  logic [31:0] spv_nxt, xl, xs;
  logic [7:0]  el, es, dif;
  logic [4:0]  dc;
  logic [53:0] sh;

  always_comb begin
    sbn = ~b[31];
    an  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    bn  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    ai  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    bi  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    sp_nxt  = 1'b1;
    spv_nxt = F_QNAN;
    if (an)                            spv_nxt = a | F_QUIET_BIT;
    else if (bn)                       spv_nxt = b | F_QUIET_BIT;
    else if (ai && bi && a[31] != sbn) spv_nxt = F_QNAN;
    else if (ai)                       spv_nxt = a;
    else if (bi)                       spv_nxt = {sbn, 8'hff, 23'd0};
    else                               sp_nxt  = 1'b0;
    swp = b[30:0] > a[30:0];
    xl  = swp ? b : a;
    xs  = swp ? a : b;
    sl  = swp ? sbn : a[31];
    el  = (xl[30:23] == 8'd0) ? 8'd1 : xl[30:23];
    es  = (xs[30:23] == 8'd0) ? 8'd1 : xs[30:23];
    dif = el - es;
    dc  = (dif > 8'd31) ? 5'd31 : dif[4:0];
    sh  = {xs[30:23] != 8'd0, xs[22:0], 3'b000, 27'd0} >> dc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sub1_r <= a[31] ^ sbn;
      s1_r   <= sl;
      z1_r   <= a[31] & sbn;
      sp1_r  <= sp_nxt;
      spv1_r <= spv_nxt;
      big1_r <= {xl[30:23] != 8'd0, xl[22:0], 3'b000};
      sml1_r <= {sh[53:28], sh[27] | (|sh[26:0])};
      e1_r   <= el;
    end
  end

  // stage 2: add or subtract significands, count leading zeros
  logic        v2_r, s2_r, z2_r, sp2_r;
  logic [31:0] spv2_r;
  logic [27:0] sum2_r;
  logic [4:0]  lz2_r;
  logic [7:0]  e2_r;
  logic [27:0] sum_nxt;

  always_comb begin
    sum_nxt = sub1_r ? {1'b0, big1_r} - {1'b0, sml1_r} : {1'b0, big1_r} + {1'b0, sml1_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r   <= s1_r;
      z2_r   <= z1_r;
      sp2_r  <= sp1_r;
      spv2_r <= spv1_r;
      sum2_r <= sum_nxt;
      lz2_r  <= clz27(sum_nxt[26:0]);
      e2_r   <= e1_r;
    end
  end

  // stage 3: normalize, stopping at the subnormal boundary, then round and pack
  logic        v3_r;
  logic [31:0] d3_r;
  logic [7:0]  lim;
  logic [4:0]  shl;
  logic [26:0] m;
  logic [8:0]  ex;
  logic [7:0]  ef;
  logic        inc;
  logic [30:0] mag;
  logic [31:0] d_nxt;

  always_comb begin
    lim = e2_r - 8'd1;
    shl = ({3'd0, lz2_r} < lim) ? lz2_r : lim[4:0];
    if (sum2_r[27]) begin
      m  = {sum2_r[27:2], sum2_r[1] | sum2_r[0]};
      ex = {1'b0, e2_r} + 9'd1;
    end else begin
      m  = sum2_r[26:0] << shl;
      ex = {1'b0, e2_r} - {4'd0, shl};
    end
    ef  = m[26] ? ex[7:0] : 8'd0;
    inc = m[2] & (m[1] | m[0] | m[3]);
    mag = {ef, m[25:3]} + {30'd0, inc};
    if (sp2_r)                 d_nxt = spv2_r;
    else if (sum2_r == 28'd0)  d_nxt = {z2_r, 31'd0};
    else if (ex >= 9'd255)     d_nxt = {s2_r, 8'hff, 23'd0};
    else                       d_nxt = {s2_r, mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r <= d_nxt;
    end
  end

  assign out_v = v3_r;
  assign d     = d3_r;

endmodule

// ----- design/float_rsqrt_approx_top.sv -----
// Throughput: one beat per cycle while the skid entry is empty; the input register and four
// three-stage float units (r*r with v*0.5 alongside, then *y, 1.5-, *r) advance together.
// A two-entry output buffer keeps the input open while one result waits to be taken.
// Reset: rst_n (synchronous, active low) clears all valid bits; no clearing pass.
module float_rsqrt_approx_top import rsqa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] result_bits
);

  logic        en;
  logic        skid_v_r, out_v_r;
  logic [31:0] skid_r, out_r;

  assign en = ~skid_v_r;

  // stage 0: capture the value and form the bit-level first guess
  logic        v0_r;
  logic [31:0] val0_r, g0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val0_r <= in_tdata;
      g0_r   <= RSQRT_MAGIC - {in_tdata[31], in_tdata[31:1]};
    end
  end

  logic        rr_v, y_v, rry_v, t_v, fin_v;
  logic [31:0] rr, y, rry, t, fin;

  rsqa_fmul u_mul_rr (
    .clk, .rst_n, .en, .in_v(v0_r), .a(g0_r), .b(g0_r), .out_v(rr_v), .p(rr)
  );

  rsqa_fmul u_mul_y (
    .clk, .rst_n, .en, .in_v(v0_r), .a(val0_r), .b(F_HALF), .out_v(y_v), .p(y)
  );

  rsqa_fmul u_mul_rry (
    .clk, .rst_n, .en, .in_v(rr_v & y_v), .a(rr), .b(y), .out_v(rry_v), .p(rry)
  );

  rsqa_fsub u_sub_t (
    .clk, .rst_n, .en, .in_v(rry_v), .a(F_ONE_HALF), .b(rry), .out_v(t_v), .d(t)
  );

  // carry the guess alongside the three units ahead of the last multiply
  logic [31:0] r_dly_r [RDLY];

  always_ff @(posedge clk) begin
    if (en) begin
      r_dly_r[0] <= g0_r;
      for (int i = 1; i < RDLY; i++) begin
        r_dly_r[i] <= r_dly_r[i-1];
      end
    end
  end

  rsqa_fmul u_mul_res (
    .clk, .rst_n, .en, .in_v(t_v), .a(r_dly_r[RDLY-1]), .b(t), .out_v(fin_v), .p(fin)
  );

  // output register plus skid entry
  logic take, cap;

  assign take = out_tready | ~out_v_r;
  assign cap  = en & fin_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= cap;
      end
    end else if (cap) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= skid_v_r ? skid_r : fin;
    end
    if (!take && cap) begin
      skid_r <= fin;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid entry held without output beat");

  a_branches_align: assert property (@(posedge clk) disable iff (!rst_n)
    rr_v == y_v) else $error("r*r and v*0.5 branches out of step");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready && cap) |=> skid_v_r)
    else $error("result dropped while output stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> (!skid_v_r && out_v_r))
    else $error("skid entry not moved to output");

endmodule

// ----- tb/float_rsqrt_approx_top_test.sv -----
// Testbench for the approximate reciprocal square root stream block.
module float_rsqrt_approx_top_test;
  import rsqa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1580;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value_bits
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] result_bits

  logic [31:0] value_q[$];
  logic [31:0] rsqrt_q[$];
  int          errors = 0;
  int          checked = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          hold_cycles = 0;
  bit          send_burst = 0;
  bit          recv_burst = 0;

  float_rsqrt_approx_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
  end

  function automatic bit is_nan(logic [31:0] a);
    return a[30:23] == 8'hff && a[22:0] != 0;
  endfunction

  // split into integer significand and exponent of its lsb
  function automatic void split_float(input logic [31:0] a, output logic [63:0] m,
                                      output int e);
    if (a[30:23] == 0) begin
      m = {41'b0, a[22:0]};
      e = -149;
    end else begin
      m = {40'b0, 1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  // round mag * 2^e to single precision, nearest-even
  function automatic logic [31:0] round_float(logic s, logic [63:0] mag, int e);
    int p, sh;
    logic [63:0] m, rem, halfw;
    longint fe;
    logic [63:0] bits;
    if (mag == 0) return {s, 31'b0};
    p = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) p = i;
    sh = p - 23;
    if (-149 - e > sh) sh = -149 - e;
    if (sh <= 0) begin
      m = mag << (-sh);
    end else if (sh > 62) begin
      m = 0;
    end else begin
      m = mag >> sh;
      rem = mag & ((64'd1 << sh) - 1);
      halfw = 64'd1 << (sh - 1);
      if (rem > halfw || (rem == halfw && m[0])) m = m + 1;
    end
    fe = longint'(e) + sh + 149;
    bits = (64'(fe) << 23) + m;
    if (bits >= 64'h7f800000) return {s, 8'hff, 23'b0};
    return {s, bits[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic s;
    logic [63:0] ma, mb;
    int ea, eb;
    bit ai, bi, az, bz;
    if (is_nan(a)) return a | F_QUIET_BIT;
    if (is_nan(b)) return b | F_QUIET_BIT;
    s = a[31] ^ b[31];
    ai = a[30:0] == 31'h7f800000;
    bi = b[30:0] == 31'h7f800000;
    az = a[30:0] == 0;
    bz = b[30:0] == 0;
    if ((ai && bz) || (bi && az)) return F_QNAN;
    if (ai || bi) return {s, 8'hff, 23'b0};
    split_float(a, ma, ea);
    split_float(b, mb, eb);
    return round_float(s, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b_in);
    logic [31:0] b, tmp;
    logic [63:0] ma, mb, big, lit, mag;
    int ea, eb, d;
    logic s;
    if (is_nan(a)) return a | F_QUIET_BIT;
    if (is_nan(b_in)) return b_in | F_QUIET_BIT;
    b = b_in ^ 32'h80000000;
    if (a[30:0] == 31'h7f800000 && b[30:0] == 31'h7f800000 && a[31] != b[31])
      return F_QNAN;
    if (a[30:0] == 31'h7f800000) return a;
    if (b[30:0] == 31'h7f800000) return b;
    split_float(a, ma, ea);
    split_float(b, mb, eb);
    if (eb > ea) begin
      tmp = a; a = b; b = tmp;
      split_float(a, ma, ea);
      split_float(b, mb, eb);
    end
    d = ea - eb;
    big = ma << 30;
    if (d <= 30) lit = mb << (30 - d);
    else if (d - 30 >= 60) lit = {63'b0, mb != 0};
    else lit = (mb >> (d - 30)) | {63'b0, (mb & ((64'd1 << (d - 30)) - 1)) != 0};
    if (a[31] == b[31]) begin
      mag = big + lit;
      s = a[31];
    end else if (big >= lit) begin
      mag = big - lit;
      s = a[31];
    end else begin
      mag = lit - big;
      s = b[31];
    end
    if (mag == 0) s = a[31] & b[31];
    return round_float(s, mag, ea - 30);
  endfunction

  function automatic logic [31:0] rsqrt_of(logic [31:0] x);
    logic [31:0] guess, y, rr, rry, t;
    guess = RSQRT_MAGIC - {x[31], x[31:1]};
    y = fp_mul(x, F_HALF);
    rr = fp_mul(guess, guess);
    rry = fp_mul(rr, y);
    t = fp_sub(F_ONE_HALF, rry);
    return fp_mul(guess, t);
  endfunction

  function automatic logic [31:0] draw_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: v[30:23] = 8'($urandom_range(100, 154));
      3:       v[30:23] = 8'($urandom_range(1, 254));
      4:       v[30:23] = 0;
      5:       v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      6:       v[30:23] = $urandom_range(0, 1) ? 8'($urandom_range(240, 254))
                                              : 8'($urandom_range(1, 10));
      7:       v = {$urandom_range(0, 1) == 1, 8'($urandom_range(0, 255)), 23'($urandom_range(0, 3))};
      default: ;
    endcase
    if ($urandom_range(0, 9) != 0 && v[30:23] != 0 && v[30:23] != 8'hff) v[31] = 0;
    return v;
  endfunction

  initial begin
    value_q.push_back(32'h00000000);
    value_q.push_back(32'h80000000);
    value_q.push_back(32'h7f800000);
    value_q.push_back(32'hff800000);
    value_q.push_back(32'h7fc00000);
    value_q.push_back(32'h7f800001);
    value_q.push_back(32'hffffffff);
    value_q.push_back(32'h00000001);
    value_q.push_back(32'h007fffff);
    value_q.push_back(32'h00800000);
    value_q.push_back(32'h7f7fffff);
    value_q.push_back(32'h3f800000);
    value_q.push_back(32'h40800000);
    value_q.push_back(32'h3e800000);
    value_q.push_back(32'hbf800000);
    value_q.push_back(32'hc0000000);
    value_q.push_back(32'h80000001);
    value_q.push_back(32'hbe000000);   // guess wraps past zero
    value_q.push_back(32'hffffffff);
    value_q.push_back(32'h55555555);
    value_q.push_back(32'haaaaaaaa);
    for (int i = 0; i < NUM_RANDOM; i++) value_q.push_back(draw_value());
  end

  // sender
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= 0;
      send_gap = 0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        rsqrt_q.push_back(rsqrt_of(in_tdata));
        nv = 0;
        if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 4);
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (value_q.size() > 0) begin
          in_tdata <= value_q.pop_front();
          nv = 1;
        end
      end
      in_tvalid <= nv;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (rsqrt_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, out_tdata);
          errors++;
        end else begin
          want = rsqrt_q.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: result_bits mismatch, expected %h actual %h",
                     $time, want, out_tdata);
            errors++;
          end
        end
        checked++;
        if (checked == 500) hold_cycles = 300;
        if ($urandom_range(0, 99) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 4);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    wait (rst_n);
    @(posedge clk);
    while (value_q.size() > 0 || in_tvalid || rsqrt_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- float_rsqrt_approx_top.f -----
design/rsqa_pkg.sv
design/rsqa_fmul.sv
design/rsqa_fsub.sv
design/float_rsqrt_approx_top.sv
tb/float_rsqrt_approx_top_test.sv
